[sv/spc_pkg.sv]
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants of the status packet checker
// Word layouts of both channels, the verdict codes, the framing constants and
// the per-byte CRC-16 step.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int unsigned CountWidth = 17;
  localparam int unsigned CrcWidth   = 16;

  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam logic [CountWidth-1:0] MinLen   = 17'd11;
  localparam logic [CountWidth-1:0] LenExtra = 17'd7;
  localparam logic [CrcWidth-1:0]   CrcPoly  = 16'h8005;

  localparam logic [7:0] HdrSync     = 8'hFF;
  localparam logic [7:0] HdrMark     = 8'hFD;
  localparam logic [7:0] HdrReserved = 8'h00;

  // Byte offsets inside the packet.
  localparam logic [CountWidth-1:0] PosSync0    = 17'd0;
  localparam logic [CountWidth-1:0] PosSync1    = 17'd1;
  localparam logic [CountWidth-1:0] PosMark     = 17'd2;
  localparam logic [CountWidth-1:0] PosReserved = 17'd3;
  localparam logic [CountWidth-1:0] PosId       = 17'd4;
  localparam logic [CountWidth-1:0] PosLenLo    = 17'd5;
  localparam logic [CountWidth-1:0] PosLenHi    = 17'd6;
  localparam logic [CountWidth-1:0] PosErr      = 17'd8;

  typedef enum logic [2:0] {
    VERDICT_OK        = 3'd0,
    VERDICT_SHORT     = 3'd1,
    VERDICT_BAD_HDR   = 3'd2,
    VERDICT_LEN_MISM  = 3'd3,
    VERDICT_BAD_CRC   = 3'd4,
    VERDICT_DEV_ERROR = 3'd5
  } verdict_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]            verdict;
    logic [7:0]            device_error;
    logic [7:0]            servo_id;
    logic [CountWidth-1:0] byte_count;
  } out_word_t;

  // One byte through the MSB-first CRC-16, eight shift steps.
  function automatic logic [CrcWidth-1:0] crc_feed(input logic [CrcWidth-1:0] crc,
                                                   input logic [7:0] b);
    logic [CrcWidth-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[CrcWidth-1]) begin
        c = {c[CrcWidth-2:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[CrcWidth-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

[sv/spc_in_if.sv]
// ----------------------------------------------------------------------------
// spc_in_if: received byte channel
// Valid/ready channel that carries one received byte and its end flag.
// ----------------------------------------------------------------------------
interface spc_in_if;
  logic              valid;
  logic              ready;
  spc_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/spc_out_if.sv]
// ----------------------------------------------------------------------------
// spc_out_if: verdict channel
// Valid/ready channel that carries one packet verdict with its reported fields.
// ----------------------------------------------------------------------------
interface spc_out_if;
  logic               valid;
  logic               ready;
  spc_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[sv/status_packet_checker.sv]
// ----------------------------------------------------------------------------
// status_packet_checker: framed status packet check with CRC-16
// Tracks header, ID, length, error byte and a CRC-16 over a byte stream and
// gives one verdict on the final byte of each packet.
// ----------------------------------------------------------------------------
// A final byte passes the input register, and its verdict the verdict register.
// Throughput: one byte per cycle; the per-byte CRC step and the checks sit
// between the input register and the verdict register. A final byte waits
// only while the previous verdict is still held by the receiver.
// Reset: all packet state returns to its idle values (count zero, header
// flag set), and both channel registers empty.
module status_packet_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  spc_in_if.sink     in_i,
  spc_out_if.source  out_o
);

  localparam int unsigned CW = spc_pkg::CountWidth;

  // Input register.
  logic              s1_valid_q;
  spc_pkg::in_word_t s1_data_q;
  logic              s1_adv;
  logic              s1_fire;

  // Packet state.
  logic [CW-1:0] count_q,    count_d;
  logic [15:0]   crc_q,      crc_d;
  logic [15:0]   tail_q,     tail_d;
  logic          hdr_ok_q,   hdr_ok_d;
  logic [15:0]   len_q,      len_d;
  logic [7:0]    id_q,       id_d;
  logic [7:0]    err_q,      err_d;

  // Verdict register.
  logic               out_valid_q;
  spc_pkg::out_word_t out_data_q;

  logic [15:0]       trailer;
  spc_pkg::verdict_e verdict;
  logic [CW-1:0]     len_plus;

  // A word that ends no packet never waits on the output side.
  assign s1_adv   = !s1_data_q.last_byte || !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && s1_adv;
  assign in_i.ready = !s1_valid_q || s1_adv;

  always_comb begin
    hdr_ok_d = hdr_ok_q;
    id_d     = id_q;
    len_d    = len_q;
    err_d    = err_q;
    unique case (count_q)
      spc_pkg::PosSync0, spc_pkg::PosSync1: begin
        if (s1_data_q.rx_byte != spc_pkg::HdrSync) hdr_ok_d = 1'b0;
      end
      spc_pkg::PosMark: begin
        if (s1_data_q.rx_byte != spc_pkg::HdrMark) hdr_ok_d = 1'b0;
      end
      spc_pkg::PosReserved: begin
        if (s1_data_q.rx_byte != spc_pkg::HdrReserved) hdr_ok_d = 1'b0;
      end
      spc_pkg::PosId:    id_d  = s1_data_q.rx_byte;
      spc_pkg::PosLenLo: len_d = {len_q[15:8], s1_data_q.rx_byte};
      spc_pkg::PosLenHi: len_d = {s1_data_q.rx_byte, len_q[7:0]};
      spc_pkg::PosErr:   err_d = s1_data_q.rx_byte;
      default: ;
    endcase

    // The byte leaving the two-byte delay line is never part of the trailer.
    if (count_q >= spc_pkg::PosMark) begin
      crc_d = spc_pkg::crc_feed(crc_q, tail_q[15:8]);
    end else begin
      crc_d = crc_q;
    end
    tail_d = {tail_q[7:0], s1_data_q.rx_byte};

    count_d = (count_q != spc_pkg::CountMax) ? count_q + 1'b1 : count_q;

    trailer  = {tail_d[7:0], tail_d[15:8]};
    len_plus = {1'b0, len_d} + spc_pkg::LenExtra;

    priority if (count_d < spc_pkg::MinLen) begin
      verdict = spc_pkg::VERDICT_SHORT;
    end else if (!hdr_ok_d) begin
      verdict = spc_pkg::VERDICT_BAD_HDR;
    end else if (len_plus != count_d) begin
      verdict = spc_pkg::VERDICT_LEN_MISM;
    end else if (crc_d != trailer) begin
      verdict = spc_pkg::VERDICT_BAD_CRC;
    end else if (err_d != 8'h00) begin
      verdict = spc_pkg::VERDICT_DEV_ERROR;
    end else begin
      verdict = spc_pkg::VERDICT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      crc_q       <= '0;
      tail_q      <= '0;
      hdr_ok_q    <= 1'b1;
      len_q       <= '0;
      id_q        <= '0;
      err_q       <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_fire && s1_data_q.last_byte) begin
        out_valid_q <= 1'b1;
        count_q     <= '0;
        crc_q       <= '0;
        tail_q      <= '0;
        hdr_ok_q    <= 1'b1;
        len_q       <= '0;
        id_q        <= '0;
        err_q       <= '0;
      end else begin
        if (out_o.ready) out_valid_q <= 1'b0;
        if (s1_fire) begin
          count_q  <= count_d;
          crc_q    <= crc_d;
          tail_q   <= tail_d;
          hdr_ok_q <= hdr_ok_d;
          len_q    <= len_d;
          id_q     <= id_d;
          err_q    <= err_d;
        end
      end
    end
  end

  // Payload registers, no reset.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) s1_data_q <= in_i.data;
    if (s1_fire && s1_data_q.last_byte) begin
      out_data_q.verdict      <= verdict;
      out_data_q.device_error <= err_d;
      out_data_q.servo_id     <= id_d;
      out_data_q.byte_count   <= count_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

[sv/spc_checker.sv]
// ----------------------------------------------------------------------------
// spc_checker: port-level assertions for the status packet checker
// Watches the verdict channel and the consistency of the reported fields.
// ----------------------------------------------------------------------------
module spc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [2:0]                     verdict_i,
  input logic [7:0]                     device_error_i,
  input logic [spc_pkg::CountWidth-1:0] byte_count_i
);

  // A stalled verdict word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(verdict_i)
      && $stable(byte_count_i) && $stable(device_error_i))
    else $error("verdict word changed while stalled");

  // A verdict covers a packet of at least its final byte.
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> byte_count_i != '0)
    else $error("verdict with zero byte count");

  // The short-packet verdict is given exactly when the count is below minimum.
  a_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((byte_count_i < spc_pkg::MinLen)
      == (verdict_i == spc_pkg::VERDICT_SHORT)))
    else $error("short verdict disagrees with byte count");

  // A good packet reports no device error.
  a_ok_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && verdict_i == spc_pkg::VERDICT_OK |-> device_error_i == 8'h00)
    else $error("ok verdict with nonzero device error");

endmodule

bind status_packet_checker spc_checker u_spc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .verdict_i      (out_o.data.verdict),
  .device_error_i (out_o.data.device_error),
  .byte_count_i   (out_o.data.byte_count)
);
